// File: hw/rtl/vector_matrix4x4_transform_top_assert.svh
// ----------------------------------------------------------------------------
// vector_matrix4x4_transform_top_assert.svh
// assertion macros for the 4x4 transform block, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef VECTOR_MATRIX4X4_TRANSFORM_TOP_ASSERT_SVH
`define VECTOR_MATRIX4X4_TRANSFORM_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define VMT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vmt assertion failed");
// next-cycle implication, sampled on clk, off while rst_n is low
`define VMT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vmt assertion failed");
`else
`define VMT_ASSERT_IMP(lbl, ante, cons)
`define VMT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// shared types and codes for the 4x4 homogeneous transform
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vmt_pkg;

  localparam int WORD_W    = 32;
  localparam int COEF_W    = 64;
  localparam int CFG_IDX_W = 4;
  localparam int NUM_REGS  = 8;
  localparam int NUM_LANES = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_LANES-1:0] vec_t;

  typedef enum logic [1:0] {
    OP_POINT     = 2'd0,
    OP_DIRECTION = 2'd1,
    OP_FULL      = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    REG_ROW0_COLS01 = 3'd0,
    REG_ROW0_COLS23 = 3'd1,
    REG_ROW1_COLS01 = 3'd2,
    REG_ROW1_COLS23 = 3'd3,
    REG_ROW2_COLS01 = 3'd4,
    REG_ROW2_COLS23 = 3'd5,
    REG_ROW3_COLS01 = 3'd6,
    REG_ROW3_COLS23 = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_sum;
  } lane_ctl_t;

  typedef struct packed {
    word_t value;
    logic  sat;
  } lane_res_t;

endpackage

// File: hw/rtl/vmt_lane.sv
// ----------------------------------------------------------------------------
// vmt_lane
// one output column: four products, their sum, truncation and saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmt_lane
  import vmt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  vec_t      vec,
  input  vec_t      coef,
  output lane_res_t res
);

  localparam int PROD_W = 2 * WORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic [SUM_W-1:0] RND_BIAS = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);

  logic signed [PROD_W-1:0] prod_r   [NUM_LANES];
  logic signed [PROD_W-1:0] prod_nxt [NUM_LANES];
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  biased;
  logic signed [SUM_W-1:0]  shifted;
  logic                     neg;
  logic                     in_range;

  // products of each vector component with its row coefficient
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod_nxt[i] = $signed(vec[i]) * $signed(coef[i]);
    end
  end

  assign sum_nxt = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1])
                 + SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]);

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    if (ctl.ld_sum) begin
      sum_r <= sum_nxt;
    end
  end

  // truncate toward zero, then clip to 32 bits
  assign neg      = sum_r[SUM_W-1];
  assign biased   = sum_r + (neg ? $signed(RND_BIAS) : $signed(SUM_W'(0)));
  assign shifted  = biased >>> FRAC_BITS;
  assign in_range = (&shifted[SUM_W-1:WORD_W-1]) | ~(|shifted[SUM_W-1:WORD_W-1]);

  always_comb begin
    res.sat = ~in_range;
    if (in_range) begin
      res.value = shifted[WORD_W-1:0];
    end else if (neg) begin
      res.value = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res.value = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

endmodule

// File: hw/rtl/vmt_merge.sv
// ----------------------------------------------------------------------------
// vmt_merge
// gathers the four lane results into the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vmt_merge
  import vmt_pkg::*;
(
  input  logic                    clk,
  input  logic                    ld,
  input  logic                    w_used,
  input  lane_res_t [NUM_LANES-1:0] lane_res,
  output logic signed [WORD_W-1:0] out_x,
  output logic signed [WORD_W-1:0] out_y,
  output logic signed [WORD_W-1:0] out_z,
  output logic signed [WORD_W-1:0] out_w,
  output logic                     out_saturated
);

  logic [WORD_W-1:0] x_r, y_r, z_r, w_r;
  logic              sat_r;
  logic [WORD_W-1:0] w_nxt;
  logic              sat_nxt;

  // w lane only counts when the operation is neither point nor direction
  assign w_nxt   = w_used ? lane_res[3].value : '0;
  assign sat_nxt = lane_res[0].sat | lane_res[1].sat | lane_res[2].sat
                 | (w_used & lane_res[3].sat);

  always_ff @(posedge clk) begin
    if (ld) begin
      x_r   <= lane_res[0].value;
      y_r   <= lane_res[1].value;
      z_r   <= lane_res[2].value;
      w_r   <= w_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_x         = $signed(x_r);
  assign out_y         = $signed(y_r);
  assign out_z         = $signed(z_r);
  assign out_w         = $signed(w_r);
  assign out_saturated = sat_r;

endmodule

// File: hw/rtl/vector_matrix4x4_transform_top.sv
// ----------------------------------------------------------------------------
// vector_matrix4x4_transform_top
// row vector times 4x4 matrix in signed fixed point, saturated results
// ----------------------------------------------------------------------------
// Takes one vector request per clock while in_stall is low and returns one
// result per request via the product, sum and output registers. Four column
// lanes work in parallel, each with four 32x32 multipliers, a registered
// 66-bit sum and a truncate-and-clip step; their results merge into the
// output register. The pipeline keeps moving into empty stages while a
// result waits. The matrix resets to identity and is written one 64-bit
// register per cycle; write it only while no request is in flight.
`timescale 1ns / 1ps

`include "vector_matrix4x4_transform_top_assert.svh"

module vector_matrix4x4_transform_top
  import vmt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_operation,
  input  logic signed [WORD_W-1:0] in_x,
  input  logic signed [WORD_W-1:0] in_y,
  input  logic signed [WORD_W-1:0] in_z,
  input  logic signed [WORD_W-1:0] in_w,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_x,
  output logic signed [WORD_W-1:0] out_y,
  output logic signed [WORD_W-1:0] out_z,
  output logic signed [WORD_W-1:0] out_w,
  output logic                     out_saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEF_W-1:0]        cfg_data
);

  localparam logic [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;

  logic [COEF_W-1:0] mreg_r [NUM_REGS];

  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;
  logic wuse1_r, wuse2_r;
  logic out_rdy, s2_rdy, s1_rdy;
  logic accept;
  logic cfg_wr;
  logic w_used_in;

  lane_ctl_t                   lane_ctl;
  vec_t                        vec;
  vec_t                        lane_coef [NUM_LANES];
  lane_res_t [NUM_LANES-1:0]   lane_res;

  // configuration
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid & cfg_ready & (cfg_index < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mreg_r[REG_ROW0_COLS01] <= {{WORD_W{1'b0}}, ONE_Q};
      mreg_r[REG_ROW0_COLS23] <= '0;
      mreg_r[REG_ROW1_COLS01] <= {ONE_Q, {WORD_W{1'b0}}};
      mreg_r[REG_ROW1_COLS23] <= '0;
      mreg_r[REG_ROW2_COLS01] <= '0;
      mreg_r[REG_ROW2_COLS23] <= {{WORD_W{1'b0}}, ONE_Q};
      mreg_r[REG_ROW3_COLS01] <= '0;
      mreg_r[REG_ROW3_COLS23] <= {ONE_Q, {WORD_W{1'b0}}};
    end else if (cfg_wr) begin
      mreg_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  // pipeline flow control
  assign out_rdy  = ~out_v_r | ~out_stall;
  assign s2_rdy   = ~s2_v_r | out_rdy;
  assign s1_rdy   = ~s1_v_r | s2_rdy;
  assign in_stall = ~s1_rdy;
  assign accept   = in_valid & s1_rdy;

  assign s1_v_nxt  = s1_rdy  ? in_valid : s1_v_r;
  assign s2_v_nxt  = s2_rdy  ? s1_v_r   : s2_v_r;
  assign out_v_nxt = out_rdy ? s2_v_r   : out_v_r;

  assign lane_ctl.ld_prod = accept;
  assign lane_ctl.ld_sum  = s2_rdy & s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ctl.ld_prod) begin
      wuse1_r <= w_used_in;
    end
    if (lane_ctl.ld_sum) begin
      wuse2_r <= wuse1_r;
    end
  end

  assign out_valid = out_v_r;

  // fourth component by operation
  always_comb begin
    vec[0] = in_x;
    vec[1] = in_y;
    vec[2] = in_z;
    case (in_operation)
      OP_POINT: begin
        vec[3]    = ONE_Q;
        w_used_in = 1'b0;
      end
      OP_DIRECTION: begin
        vec[3]    = '0;
        w_used_in = 1'b0;
      end
      default: begin
        vec[3]    = in_w;
        w_used_in = 1'b1;
      end
    endcase
  end

  // column c of the matrix for lane c
  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_row
      assign lane_coef[c][i] = mreg_r[i * 2 + c / 2][WORD_W * (c % 2) +: WORD_W];
    end

    vmt_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .vec  (vec),
      .coef (lane_coef[c]),
      .res  (lane_res[c])
    );
  end

  vmt_merge u_merge (
    .clk           (clk),
    .ld            (out_rdy & s2_v_r),
    .w_used        (wuse2_r),
    .lane_res      (lane_res),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_w         (out_w),
    .out_saturated (out_saturated)
  );

  `VMT_ASSERT_IMP(a_sat_clipped, out_valid && out_saturated, out_x == 32'sh7fffffff || out_x == 32'sh80000000 || out_y == 32'sh7fffffff || out_y == 32'sh80000000 || out_z == 32'sh7fffffff || out_z == 32'sh80000000 || out_w == 32'sh7fffffff || out_w == 32'sh80000000)
  `VMT_ASSERT_NXT(a_cfg_written, cfg_wr, mreg_r[$past(cfg_index[2:0])] == $past(cfg_data))
  `VMT_ASSERT_NXT(a_s1_held, s1_v_r && !s2_rdy, s1_v_r)
  `VMT_ASSERT_NXT(a_s2_held, s2_v_r && !out_rdy, s2_v_r && out_v_r)

endmodule
